[hw/rtl/i2cmbe_pkg.sv]
// Package with the word types, state type and codes of the I2C master byte engine.
`timescale 1ns / 1ps
`default_nettype none
package i2cmbe_pkg;

   // Command codes on the func field.
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_RACK  = 3'd4;
   localparam logic [2:0] CMD_RNACK = 3'd5;

   // Bus sequencer phases.
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_ST_WAIT   = 4'd1;
   localparam logic [3:0] PH_ST_HOLD1  = 4'd2;
   localparam logic [3:0] PH_ST_HOLD2  = 4'd3;
   localparam logic [3:0] PH_SP_LOW    = 4'd4;
   localparam logic [3:0] PH_SP_WAIT   = 4'd5;
   localparam logic [3:0] PH_SP_HOLD   = 4'd6;
   localparam logic [3:0] PH_SP_TAIL   = 4'd7;
   localparam logic [3:0] PH_BIT_LOW   = 4'd8;
   localparam logic [3:0] PH_BIT_WAIT  = 4'd9;
   localparam logic [3:0] PH_BIT_HIGH  = 4'd10;
   localparam logic [3:0] PH_BYTE_TAIL = 4'd11;

   // Configuration register indexes.
   localparam logic CSR_LOW_TIME  = 1'b0;
   localparam logic CSR_HIGH_TIME = 1'b1;

   localparam logic [15:0] TIME_RESET = 16'd5;
   localparam logic [3:0]  LAST_DATA_BIT = 4'd7;
   localparam logic [3:0]  DATA_BITS = 4'd8;
   localparam logic [3:0]  BITS_PER_BYTE = 4'd9;
   localparam logic [7:0]  BYTE_ONES = 8'hff;
   localparam logic [7:0]  BYTE_ZERO = 8'h00;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] write_byte;
      logic       scl_in;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       nack_seen;
      logic       cmd_rejected;
   } rsp_word_type;

   // Sequencer state apart from the tick timer, whose width is a parameter.
   typedef struct packed {
      logic [3:0] phase;
      logic [3:0] bit_count;
      logic [7:0] shift_byte;
      logic [2:0] active_command;
      logic       scl_drive;
      logic       sda_drive;
      logic [7:0] last_read;
      logic       last_nack;
   } seq_state_type;

endpackage
`default_nettype wire

[hw/rtl/i2cmbe_step.sv]
// Next-state and result logic for one clock tick of the I2C byte sequencer.
`timescale 1ns / 1ps
`default_nettype none
module i2cmbe_step #(
   parameter int TIMER_BITS = 16
) (
   input  i2cmbe_pkg::seq_state_type cur_state,
   input  logic [TIMER_BITS-1:0]     cur_timer,
   input  i2cmbe_pkg::req_word_type  req_word,
   input  logic [15:0]               low_time,
   input  logic [15:0]               high_time,
   output i2cmbe_pkg::seq_state_type next_state,
   output logic [TIMER_BITS-1:0]     next_timer,
   output i2cmbe_pkg::rsp_word_type  rsp_word
);
   import i2cmbe_pkg::*;

   // Mask a time setting to the timer width; zero counts as one tick.
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] v);
      logic [TIMER_BITS+15:0] ext;
      logic [TIMER_BITS-1:0]  t;
      ext = {{TIMER_BITS{1'b0}}, v};
      t = ext[TIMER_BITS-1:0];
      return (t == '0) ? TIMER_BITS'(1) : t;
   endfunction

   // SDA level to drive for the given bit of the current byte.
   function automatic logic sda_for_bit(input logic [3:0] bit_idx,
                                        input logic [2:0] cmd,
                                        input logic [7:0] shifter);
      logic is_write;
      is_write = (cmd == CMD_WRITE);
      if (bit_idx < DATA_BITS) begin
         return is_write ? shifter[7] : 1'b1;
      end
      if (is_write) begin
         return 1'b1;
      end
      return (cmd == CMD_RACK) ? 1'b0 : 1'b1;
   endfunction

   logic                  is_cmd;
   logic                  expired;
   logic                  done;
   logic                  rejected;
   logic [7:0]            shifted;
   logic [3:0]            bit_next;

   assign is_cmd   = req_word.func inside {[CMD_START:CMD_RNACK]};
   assign expired  = (cur_timer <= TIMER_BITS'(1));
   assign shifted  = {cur_state.shift_byte[6:0], req_word.sda_in};
   assign bit_next = cur_state.bit_count + 4'd1;

   always_comb begin
      next_state = cur_state;
      next_timer = cur_timer;
      done       = 1'b0;
      rejected   = 1'b0;
      if (cur_state.phase != PH_IDLE) begin
         rejected = is_cmd;
         // Timed phases count down while not yet expired.
         if (!expired) begin
            next_timer = cur_timer - TIMER_BITS'(1);
         end
         case (cur_state.phase)
            PH_ST_WAIT: begin
               if (req_word.scl_in) begin
                  next_timer = timer_load(high_time);
                  next_state.phase = PH_ST_HOLD1;
               end
            end
            PH_ST_HOLD1: begin
               if (expired) begin
                  next_state.sda_drive = 1'b0;
                  next_timer = timer_load(high_time);
                  next_state.phase = PH_ST_HOLD2;
               end
            end
            PH_ST_HOLD2: begin
               if (expired) begin
                  next_state.scl_drive = 1'b0;
                  next_state.sda_drive = 1'b1;
                  next_state.phase = PH_IDLE;
                  done = 1'b1;
               end
            end
            PH_SP_LOW: begin
               if (expired) begin
                  next_state.scl_drive = 1'b1;
                  next_state.phase = PH_SP_WAIT;
               end
            end
            PH_SP_WAIT: begin
               if (req_word.scl_in) begin
                  next_timer = timer_load(high_time);
                  next_state.phase = PH_SP_HOLD;
               end
            end
            PH_SP_HOLD: begin
               if (expired) begin
                  next_state.sda_drive = 1'b1;
                  next_timer = timer_load(low_time);
                  next_state.phase = PH_SP_TAIL;
               end
            end
            PH_SP_TAIL: begin
               if (expired) begin
                  next_state.phase = PH_IDLE;
                  done = 1'b1;
               end
            end
            PH_BIT_LOW: begin
               if (expired) begin
                  next_state.scl_drive = 1'b1;
                  next_state.phase = PH_BIT_WAIT;
               end
            end
            PH_BIT_WAIT: begin
               if (req_word.scl_in) begin
                  if (cur_state.bit_count < DATA_BITS) begin
                     next_state.shift_byte = shifted;
                     if (cur_state.bit_count == LAST_DATA_BIT &&
                         cur_state.active_command != CMD_WRITE) begin
                        next_state.last_read = shifted;
                     end
                  end else if (cur_state.active_command == CMD_WRITE) begin
                     next_state.last_nack = req_word.sda_in;
                  end
                  next_timer = timer_load(high_time);
                  next_state.phase = PH_BIT_HIGH;
               end
            end
            PH_BIT_HIGH: begin
               if (expired) begin
                  next_state.scl_drive = 1'b0;
                  next_state.bit_count = bit_next;
                  next_timer = timer_load(low_time);
                  if (bit_next >= BITS_PER_BYTE) begin
                     next_state.phase = PH_BYTE_TAIL;
                  end else begin
                     next_state.sda_drive = sda_for_bit(bit_next,
                        cur_state.active_command, cur_state.shift_byte);
                     next_state.phase = PH_BIT_LOW;
                  end
               end
            end
            PH_BYTE_TAIL: begin
               if (expired) begin
                  next_state.sda_drive = 1'b1;
                  next_state.shift_byte = BYTE_ONES;
                  next_state.phase = PH_IDLE;
                  done = 1'b1;
               end
            end
            default: begin
               next_timer = cur_timer;
               next_state.phase = PH_IDLE;
            end
         endcase
      end else if (is_cmd) begin
         next_state.active_command = req_word.func;
         case (req_word.func)
            CMD_START: begin
               next_state.scl_drive = 1'b1;
               next_state.sda_drive = 1'b1;
               next_state.phase = PH_ST_WAIT;
            end
            CMD_STOP: begin
               next_state.scl_drive = 1'b0;
               next_state.sda_drive = 1'b0;
               next_timer = timer_load(low_time);
               next_state.phase = PH_SP_LOW;
            end
            default: begin
               next_state.shift_byte = (req_word.func == CMD_WRITE) ?
                                       req_word.write_byte : BYTE_ONES;
               next_state.bit_count = '0;
               next_state.scl_drive = 1'b0;
               next_state.sda_drive = (req_word.func == CMD_WRITE) ?
                                      req_word.write_byte[7] : 1'b1;
               next_timer = timer_load(low_time);
               next_state.phase = PH_BIT_LOW;
            end
         endcase
      end
   end

   always_comb begin
      rsp_word.scl_release  = next_state.scl_drive;
      rsp_word.sda_release  = next_state.sda_drive;
      rsp_word.busy_res     = (next_state.phase != PH_IDLE);
      rsp_word.done_res     = done;
      rsp_word.read_byte    = next_state.last_read;
      rsp_word.nack_seen    = next_state.last_nack;
      rsp_word.cmd_rejected = rejected;
   end

endmodule
`default_nettype wire

[hw/rtl/i2c_master_byte_engine.sv]
// Top level of the I2C master byte engine: channel registers, sequencer state and settings.
//
// Each request word is one clock tick of the bus: an optional command (start,
// stop, write byte, read with ACK, read with NACK), the byte to write and the
// sampled SCL and SDA pin levels. Every request word yields exactly one
// response word carrying the SCL/SDA drive levels, busy, a done pulse, the
// last byte read, the last write's ACK bit and a command-rejected flag.
// A word is accepted on a rising edge where valid is high and stall is low.
// The request is captured in an input register; when the response register is
// free, it runs through the sequencer logic and the result loads the response
// register, from which the response word is taken. One word is taken every
// cycle while req_stall is low; the single-tick sequencer step sets that rate.
// When the response register is full and rsp_stall is high, the request
// register holds its word and req_stall rises; nothing is lost or repeated.
// Reset (synchronous, active high) returns the sequencer to idle with both
// lines released, clears both registers and sets both time settings to 5.
// The csr_ port writes the low time (index 0) and high time (index 1); write
// them only while the engine is idle.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_byte_engine #(
   parameter int TIMER_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  i2cmbe_pkg::req_word_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output i2cmbe_pkg::rsp_word_type rsp_data,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [15:0]              csr_wdata
);
   import i2cmbe_pkg::*;

   // Input register.
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;

   // Response register.
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;

   // Sequencer state and time settings.
   seq_state_type         state_ff, state_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [15:0]           low_time_ff, high_time_ff;
   rsp_word_type          step_word;

   logic out_free;
   logic advance;
   logic take_req;

   // The step runs when the response register is empty or being emptied.
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign take_req    = req_valid && !req_stall;
   assign in_valid_in = take_req || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   i2cmbe_step #(
      .TIMER_BITS(TIMER_BITS)
   ) u_step (
      .cur_state (state_ff),
      .cur_timer (timer_ff),
      .req_word  (in_word_ff),
      .low_time  (low_time_ff),
      .high_time (high_time_ff),
      .next_state(state_in),
      .next_timer(timer_in),
      .rsp_word  (step_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_word_ff <= step_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_IDLE;
         state_ff.bit_count      <= '0;
         state_ff.shift_byte     <= BYTE_ONES;
         state_ff.active_command <= CMD_NONE;
         state_ff.scl_drive      <= 1'b1;
         state_ff.sda_drive      <= 1'b1;
         state_ff.last_read      <= BYTE_ZERO;
         state_ff.last_nack      <= 1'b0;
         timer_ff                <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         timer_ff <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_time_ff  <= TIME_RESET;
         high_time_ff <= TIME_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOW_TIME:  low_time_ff  <= csr_wdata;
            CSR_HIGH_TIME: high_time_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule
`default_nettype wire
